### src/scd_pkg.sv
package scd_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int DEPTH_W        = 16;
    localparam int MEAN_RAY_W     = 14;
    localparam int MEAN_DEPTH_W   = 20;
    localparam int CFG_W          = 16;
    localparam int CFG_ADDR_W     = 1;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 40;

    // Defaults for the top-level parameters
    localparam int MAX_RAYS_DEF   = 1024;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;

    // Segment queue between front and divider
    localparam int SEG_FIFO_DEPTH = 4;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_VALID_DEPTH_RST = 16'd20;
    localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RST  = 16'd100;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_VALID_DEPTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_THRESHOLD  = 1'b1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

### src/scan_cylinder_detector.sv
// Input: one beat per cycle while the segment queue has room; the queue
//   (4 entries) fills only when segments close faster than the divider drains.
// Output: a mean pair leaves once the shared bit-serial divider has formed
//   QW quotient bits, where QW = sum width + FRAC_BITS (31 by default); the
//   divider takes no new segment until the last mean pair has been taken.
// Reset: synchronous, active low; clears scan state, queue and divider, and
//   loads min_valid_depth = 20 and edge_threshold = 100.
module scan_cylinder_detector #(
    parameter int MAX_RAYS   = scd_pkg::MAX_RAYS_DEF,
    parameter int DEPTH_BITS = scd_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = scd_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [scd_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // [15:0] depth
    input  logic                              i_s_axis_tlast,  // last_sample
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [13:0] mean_ray, [33:14] mean_depth, [39:34] zero
    output logic [scd_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [scd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [scd_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import scd_pkg::*;

    localparam int DW        = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
    localparam int IDX_W     = $clog2(MAX_RAYS + 1);
    localparam int RAY_TOTAL = MAX_RAYS * (MAX_RAYS - 1) / 2;
    localparam int RSUM_RAW  = $clog2(RAY_TOTAL + 1);
    localparam int RSUM_W    = (RSUM_RAW > IDX_W) ? RSUM_RAW : IDX_W;
    localparam int ENTRY_W   = RSUM_W + DW + 2 * IDX_W;

    logic [CFG_W-1:0] r_min_valid_depth;
    logic [CFG_W-1:0] r_edge_threshold;

    t_fifo_status        w_fifo_status;
    logic                w_push;
    logic [ENTRY_W-1:0]  w_push_data;
    logic                w_pop;
    logic [ENTRY_W-1:0]  w_pop_data;
    logic [MEAN_RAY_W-1:0]   w_mean_ray;
    logic [MEAN_DEPTH_W-1:0] w_mean_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_valid_depth <= MIN_VALID_DEPTH_RST;
            r_edge_threshold  <= EDGE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_VALID_DEPTH: r_min_valid_depth <= i_cfg_wdata;
                CFG_EDGE_THRESHOLD:  r_edge_threshold  <= i_cfg_wdata;
                default: begin
                    r_min_valid_depth <= r_min_valid_depth;
                    r_edge_threshold  <= r_edge_threshold;
                end
            endcase
        end
    end

    scd_front #(
        .MAX_RAYS   (MAX_RAYS),
        .DEPTH_BITS (DEPTH_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_axis_tvalid),
        .o_ready           (o_s_axis_tready),
        .i_depth           (i_s_axis_tdata[DEPTH_W-1:0]),
        .i_last            (i_s_axis_tlast),
        .i_min_valid_depth (r_min_valid_depth),
        .i_edge_threshold  (r_edge_threshold),
        .i_fifo_status     (w_fifo_status),
        .o_push            (w_push),
        .o_push_data       (w_push_data)
    );

    scd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (SEG_FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_fifo_status)
    );

    scd_divider #(
        .MAX_RAYS   (MAX_RAYS),
        .DEPTH_BITS (DEPTH_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_divider (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_status (w_fifo_status),
        .i_entry       (w_pop_data),
        .o_pop         (w_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_mean_ray    (w_mean_ray),
        .o_mean_depth  (w_mean_depth)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({w_mean_depth, w_mean_ray});

endmodule

### src/scd_front.sv
module scd_front #(
    parameter int MAX_RAYS   = scd_pkg::MAX_RAYS_DEF,
    parameter int DEPTH_BITS = scd_pkg::DEPTH_BITS_DEF,
    parameter int ENTRY_W    = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [scd_pkg::DEPTH_W-1:0] i_depth,
    input  logic                      i_last,
    input  logic [scd_pkg::CFG_W-1:0] i_min_valid_depth,
    input  logic [scd_pkg::CFG_W-1:0] i_edge_threshold,
    input  scd_pkg::t_fifo_status     i_fifo_status,
    output logic                      o_push,
    output logic [ENTRY_W-1:0]        o_push_data
);
    import scd_pkg::*;

    localparam int DW        = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
    localparam int IDX_W     = $clog2(MAX_RAYS + 1);
    localparam int CNT_W     = IDX_W;
    localparam int RAY_TOTAL = MAX_RAYS * (MAX_RAYS - 1) / 2;
    localparam int RSUM_RAW  = $clog2(RAY_TOTAL + 1);
    localparam int RSUM_W    = (RSUM_RAW > IDX_W) ? RSUM_RAW : IDX_W;
    localparam int DSUM_W    = DW + CNT_W;
    localparam int DIFF_W    = CFG_W + 2;

    logic [DW-1:0]     r_older, n_older;
    logic [DW-1:0]     r_middle, n_middle;
    logic [IDX_W-1:0]  r_ray_index, n_ray_index;
    logic              r_in_seg, n_in_seg;
    logic [RSUM_W-1:0] r_ray_sum, n_ray_sum;
    logic [DSUM_W-1:0] r_depth_sum, n_depth_sum;
    logic [CNT_W-1:0]  r_ray_count, n_ray_count;

    logic                     w_accept;
    logic [DW-1:0]            w_d;
    logic [IDX_W-1:0]         w_idx;
    logic                     w_pair_valid;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_thr2;
    logic                     w_fall;
    logic                     w_rise;
    logic                     w_mid_valid;

    // Accept only when a segment result would surely find room
    assign o_ready  = !i_fifo_status.full;
    assign w_accept = i_valid && o_ready;
    assign w_d      = i_depth[DW-1:0];
    assign w_idx    = r_ray_index - IDX_W'(1);

    assign w_pair_valid = (r_ray_index >= IDX_W'(2))
                       && (CFG_W'(r_older) > i_min_valid_depth)
                       && (CFG_W'(w_d) > i_min_valid_depth);
    assign w_diff = w_pair_valid
                  ? ($signed(DIFF_W'(w_d)) - $signed(DIFF_W'(r_older)))
                  : '0;
    assign w_thr2 = $signed({1'b0, i_edge_threshold, 1'b0});
    assign w_fall = w_diff <= -w_thr2;
    assign w_rise = w_diff >= w_thr2;
    assign w_mid_valid = CFG_W'(r_middle) > i_min_valid_depth;

    assign o_push_data = ENTRY_W'({r_ray_count, r_depth_sum, r_ray_sum});

    always_comb begin
        n_older     = r_older;
        n_middle    = r_middle;
        n_ray_index = r_ray_index;
        n_in_seg    = r_in_seg;
        n_ray_sum   = r_ray_sum;
        n_depth_sum = r_depth_sum;
        n_ray_count = r_ray_count;
        o_push      = 1'b0;
        if (w_accept) begin
            if (r_ray_index < IDX_W'(MAX_RAYS)) begin
                // ray index-1 is finished now that its right neighbor is here
                if (r_ray_index != '0) begin
                    priority if (w_fall) begin
                        n_in_seg    = 1'b1;
                        n_ray_sum   = RSUM_W'(w_idx);
                        n_depth_sum = DSUM_W'(r_middle);
                        n_ray_count = CNT_W'(1);
                    end else if (w_rise) begin
                        o_push   = r_in_seg;
                        n_in_seg = 1'b0;
                    end else if (r_in_seg && w_mid_valid) begin
                        n_ray_sum   = r_ray_sum + RSUM_W'(w_idx);
                        n_depth_sum = r_depth_sum + DSUM_W'(r_middle);
                        n_ray_count = r_ray_count + CNT_W'(1);
                    end
                end
                n_older     = r_middle;
                n_middle    = w_d;
                n_ray_index = r_ray_index + IDX_W'(1);
            end
            // the last ray has a zero derivative and cannot close a segment
            if (i_last) begin
                n_older     = '0;
                n_middle    = '0;
                n_ray_index = '0;
                n_in_seg    = 1'b0;
                n_ray_sum   = '0;
                n_depth_sum = '0;
                n_ray_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_middle    <= '0;
            r_ray_index <= '0;
            r_in_seg    <= 1'b0;
            r_ray_sum   <= '0;
            r_depth_sum <= '0;
            r_ray_count <= '0;
        end else begin
            r_older     <= n_older;
            r_middle    <= n_middle;
            r_ray_index <= n_ray_index;
            r_in_seg    <= n_in_seg;
            r_ray_sum   <= n_ray_sum;
            r_depth_sum <= n_depth_sum;
            r_ray_count <= n_ray_count;
        end
    end

endmodule

### src/scd_fifo.sv
module scd_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = scd_pkg::SEG_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_push_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_pop_data,
    output scd_pkg::t_fifo_status o_status
);
    import scd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    logic w_push_ok;
    logic w_pop_ok;

    assign o_status.full  = r_count == (AW+1)'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign w_push_ok      = i_push && !o_status.full;
    assign w_pop_ok       = i_pop && !o_status.empty;
    assign o_pop_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            unique case ({w_push_ok, w_pop_ok})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/scd_divider.sv
module scd_divider #(
    parameter int MAX_RAYS   = scd_pkg::MAX_RAYS_DEF,
    parameter int DEPTH_BITS = scd_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = scd_pkg::FRAC_BITS_DEF,
    parameter int ENTRY_W    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scd_pkg::t_fifo_status         i_fifo_status,
    input  logic [ENTRY_W-1:0]            i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [scd_pkg::MEAN_RAY_W-1:0]   o_mean_ray,
    output logic [scd_pkg::MEAN_DEPTH_W-1:0] o_mean_depth
);
    import scd_pkg::*;

    localparam int DW        = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
    localparam int IDX_W     = $clog2(MAX_RAYS + 1);
    localparam int CNT_W     = IDX_W;
    localparam int RAY_TOTAL = MAX_RAYS * (MAX_RAYS - 1) / 2;
    localparam int RSUM_RAW  = $clog2(RAY_TOTAL + 1);
    localparam int RSUM_W    = (RSUM_RAW > IDX_W) ? RSUM_RAW : IDX_W;
    localparam int DSUM_W    = DW + CNT_W;
    localparam int SUM_W     = (RSUM_W > DSUM_W) ? RSUM_W : DSUM_W;
    localparam int QW        = SUM_W + FRAC_BITS;
    localparam int STEP_W    = $clog2(QW);
    localparam int SAT_W     = (QW > MEAN_DEPTH_W) ? QW : MEAN_DEPTH_W;

    t_div_state r_state, n_state;

    logic [QW-1:0]     r_rq;
    logic [QW-1:0]     r_dq;
    logic [CNT_W:0]    r_rrem;
    logic [CNT_W:0]    r_drem;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_step;

    logic [RSUM_W-1:0] w_in_rsum;
    logic [DSUM_W-1:0] w_in_dsum;
    logic [CNT_W-1:0]  w_in_cnt;
    logic [CNT_W:0]    w_rtry, w_dtry;
    logic              w_rge, w_dge;
    logic [CNT_W:0]    n_rrem, n_drem;
    logic [QW-1:0]     n_rq, n_dq;
    logic              w_last_step;

    assign {w_in_cnt, w_in_dsum, w_in_rsum} = i_entry[CNT_W+DSUM_W+RSUM_W-1:0];

    // Restoring division, one quotient bit per cycle for both means at once;
    // the dividend shifts out of the top while quotient bits enter below.
    assign w_rtry = {r_rrem[CNT_W-1:0], r_rq[QW-1]};
    assign w_dtry = {r_drem[CNT_W-1:0], r_dq[QW-1]};
    assign w_rge  = w_rtry >= {1'b0, r_cnt};
    assign w_dge  = w_dtry >= {1'b0, r_cnt};
    assign n_rrem = w_rge ? (w_rtry - {1'b0, r_cnt}) : w_rtry;
    assign n_drem = w_dge ? (w_dtry - {1'b0, r_cnt}) : w_dtry;
    assign n_rq   = {r_rq[QW-2:0], w_rge};
    assign n_dq   = {r_dq[QW-2:0], w_dge};
    assign w_last_step = r_step == STEP_W'(QW - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (!i_fifo_status.empty) n_state = DIV_RUN;
            DIV_RUN:  if (w_last_step) n_state = DIV_DONE;
            DIV_DONE: if (i_ready) n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            DIV_IDLE: o_pop = !i_fifo_status.empty;
            DIV_RUN:  o_pop = 1'b0;
            DIV_DONE: o_valid = 1'b1;
            default: begin
                o_pop   = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    // Means saturate to the field's largest value
    assign o_mean_ray   = (SAT_W'(r_rq) > SAT_W'({MEAN_RAY_W{1'b1}}))
                        ? {MEAN_RAY_W{1'b1}} : MEAN_RAY_W'(r_rq);
    assign o_mean_depth = (SAT_W'(r_dq) > SAT_W'({MEAN_DEPTH_W{1'b1}}))
                        ? {MEAN_DEPTH_W{1'b1}} : MEAN_DEPTH_W'(r_dq);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rq   <= QW'(w_in_rsum) << FRAC_BITS;
            r_dq   <= QW'(w_in_dsum) << FRAC_BITS;
            r_rrem <= '0;
            r_drem <= '0;
            r_cnt  <= w_in_cnt;
            r_step <= '0;
        end else if (r_state == DIV_RUN) begin
            r_rq   <= n_rq;
            r_dq   <= n_dq;
            r_rrem <= n_rrem;
            r_drem <= n_drem;
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/scd_checker.sv
module scd_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [scd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import scd_pkg::*;

    // A stalled output beat keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    // Divider needs a fresh run between results
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=> !o_m_axis_tvalid)
        else $error("results delivered on consecutive cycles");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result present right after reset");

    // Queue is empty after reset, so input is open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind scan_cylinder_detector scd_port_checker u_scd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
